FILE: hdl/lpbu_pkg.sv
// lpbu_pkg: shared types and constants for the led pixel byte unpacker
// used by lpbu_ctrl, lpbu_datapath, the top level and the checker
package lpbu_pkg;

  localparam int MaxSegment = 64;
  localparam int MaxPixels  = 4096;

  localparam int ByteW   = 8;
  localparam int IndexW  = 20;
  localparam int FirstW  = 12;
  localparam int LimitW  = 12;
  localparam int SegW    = 7;
  localparam int FmtW    = 3;
  localparam int KindW   = 2;
  localparam int NumW    = 13;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 12;
  localparam int LimCmpW = 17;

  localparam logic [NumW-1:0] NumMax = {NumW{1'b1}};

  localparam logic [CfgIdxW-1:0] RegPixelFormat  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFirstLed     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPixelLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSegmentLen   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegExtraKind    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegExtraDefault = 3'd5;

  localparam logic [FmtW-1:0] FmtRgb  = 3'd0;
  localparam logic [FmtW-1:0] FmtBgr  = 3'd1;
  localparam logic [FmtW-1:0] FmtGrb  = 3'd2;
  localparam logic [FmtW-1:0] FmtRgba = 3'd3;
  localparam logic [FmtW-1:0] FmtRgbw = 3'd4;

  localparam logic [KindW-1:0] KindNone   = 2'd0;
  localparam logic [KindW-1:0] KindDimmer = 2'd1;
  localparam logic [KindW-1:0] KindWhite  = 2'd2;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit_start;
    logic last_copy;
  } sts_t;

endpackage

FILE: hdl/led_pixel_byte_unpacker_core.sv
// led_pixel_byte_unpacker_core: top level of the led pixel byte unpacker
// depends on lpbu_pkg, lpbu_ctrl and lpbu_datapath
//
// input channel: one raw byte per beat (data_byte_i) with buffer_start_i
// marking the first byte of a buffer; in_valid_i / in_stall_o
// output channel: one LED write per beat (index, colour, extra, run_end_o)
// on out_valid_o / out_stall_i
// a byte that does not complete a pixel, or completes one beyond the pixel
// limit or with a zero segment length, gives no beat
// a byte that completes a counted pixel gives segment-length beats, one per
// cycle while the receiver does not stall; the pixel is registered when the
// byte is taken and each copy is then loaded into the output register; input
// is stalled until the last copy sits in the output register, and the copy
// counter only starts once the pixel is complete
// a stall on the output holds the current beat and halts the copy counter
// reset clears the configuration to its defaults, the byte phase, the pixel
// count, the LED offset and the output valid; no clearing pass is needed
module led_pixel_byte_unpacker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpbu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpbu_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lpbu_pkg::ByteW-1:0]    data_byte_i,
  input  logic                          buffer_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpbu_pkg::IndexW-1:0]   led_index_o,
  output logic [lpbu_pkg::ByteW-1:0]    red_o,
  output logic [lpbu_pkg::ByteW-1:0]    green_o,
  output logic [lpbu_pkg::ByteW-1:0]    blue_o,
  output logic [lpbu_pkg::ByteW-1:0]    extra_o,
  output logic                          run_end_o
);

  lpbu_pkg::cmd_t cmd;
  lpbu_pkg::sts_t sts;

  lpbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lpbu_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .buffer_start_i (buffer_start_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .led_index_o    (led_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .extra_o        (extra_o),
    .run_end_o      (run_end_o)
  );

endmodule

FILE: hdl/lpbu_ctrl.sv
// lpbu_ctrl: sequencer that takes input beats and steps out the pixel copies
// depends on lpbu_pkg (cmd_t, sts_t)
module lpbu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  lpbu_pkg::sts_t sts_i,
  output lpbu_pkg::cmd_t cmd_o
);

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_o.accept = in_valid_i && (state_q == StIdle);
  assign cmd_o.load   = (state_q == StEmit) && out_free;
  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.accept && sts_i.emit_start) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (cmd_o.load && sts_i.last_copy) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/lpbu_datapath.sv
// lpbu_datapath: config registers, byte grouping, pixel counting and copy output
// depends on lpbu_pkg (widths, register and format codes, cmd_t, sts_t)
module lpbu_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpbu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lpbu_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [lpbu_pkg::ByteW-1:0]     data_byte_i,
  input  logic                           buffer_start_i,
  input  lpbu_pkg::cmd_t                 cmd_i,
  output lpbu_pkg::sts_t                 sts_o,
  output logic [lpbu_pkg::IndexW-1:0]    led_index_o,
  output logic [lpbu_pkg::ByteW-1:0]     red_o,
  output logic [lpbu_pkg::ByteW-1:0]     green_o,
  output logic [lpbu_pkg::ByteW-1:0]     blue_o,
  output logic [lpbu_pkg::ByteW-1:0]     extra_o,
  output logic                           run_end_o
);

  localparam logic [lpbu_pkg::SegW-1:0] SegMax = lpbu_pkg::SegW'(lpbu_pkg::MaxSegment);
  localparam logic [lpbu_pkg::LimCmpW-1:0] LimMax =
    lpbu_pkg::LimCmpW'(lpbu_pkg::MaxPixels);

  // configuration
  logic [lpbu_pkg::FmtW-1:0]   fmt_q;
  logic [lpbu_pkg::FirstW-1:0] first_q;
  logic [lpbu_pkg::LimitW-1:0] limit_q;
  logic [lpbu_pkg::SegW-1:0]   seg_cfg_q;
  logic [lpbu_pkg::KindW-1:0]  kind_q;
  logic [lpbu_pkg::ByteW-1:0]  xdef_q;

  // buffer state
  logic [1:0]                   phase_q, phase_d;
  logic [lpbu_pkg::ByteW-1:0]   held_q [3];
  logic [lpbu_pkg::NumW-1:0]    num_q, num_d;
  logic [lpbu_pkg::IndexW-1:0]  base_q, base_d;

  // pixel being copied out
  logic [lpbu_pkg::ByteW-1:0]   pr_q, pg_q, pb_q, px_q;
  logic [lpbu_pkg::IndexW-1:0]  idx_q;
  logic [lpbu_pkg::SegW-1:0]    seg_q, cnt_q;

  // output register
  logic [lpbu_pkg::IndexW-1:0]  led_q;
  logic [lpbu_pkg::ByteW-1:0]   r_q, g_q, b_q, x_q;
  logic                         end_q;

  logic                         four, complete, in_limit;
  logic [1:0]                   phase_eff;
  logic [lpbu_pkg::NumW-1:0]    num_eff;
  logic [lpbu_pkg::IndexW-1:0]  base_eff;
  logic [lpbu_pkg::SegW-1:0]    seg_sat;
  logic [lpbu_pkg::LimCmpW-1:0] lim_sat;
  logic [lpbu_pkg::ByteW-1:0]   b0, b1, b2;
  logic [lpbu_pkg::ByteW-1:0]   r_d, g_d, b_d, x_d;

  assign four      = (fmt_q == lpbu_pkg::FmtRgba) || (fmt_q == lpbu_pkg::FmtRgbw);
  assign phase_eff = buffer_start_i ? 2'd0 : phase_q;
  assign num_eff   = buffer_start_i ? '0 : num_q;
  assign base_eff  = buffer_start_i ? '0 : base_q;
  assign complete  = four ? (phase_eff == 2'd3) : (phase_eff >= 2'd2);
  assign seg_sat   = (seg_cfg_q > SegMax) ? SegMax : seg_cfg_q;
  assign lim_sat   = (lpbu_pkg::LimCmpW'(limit_q) > LimMax) ? LimMax
                                                          : lpbu_pkg::LimCmpW'(limit_q);
  assign in_limit  = lpbu_pkg::LimCmpW'(num_eff) < lim_sat;

  assign b0 = held_q[0];
  assign b1 = held_q[1];
  assign b2 = (phase_eff == 2'd2) ? data_byte_i : held_q[2];

  always_comb begin
    case (fmt_q)
      lpbu_pkg::FmtBgr: begin
        r_d = b2; g_d = b1; b_d = b0;
      end
      lpbu_pkg::FmtGrb: begin
        r_d = b1; g_d = b0; b_d = b2;
      end
      default: begin
        r_d = b0; g_d = b1; b_d = b2;
      end
    endcase
    if ((fmt_q == lpbu_pkg::FmtRgba && kind_q == lpbu_pkg::KindDimmer) ||
        (fmt_q == lpbu_pkg::FmtRgbw && kind_q == lpbu_pkg::KindWhite)) begin
      x_d = data_byte_i;
    end else begin
      x_d = xdef_q;
    end
  end

  always_comb begin
    phase_d = complete ? 2'd0 : phase_eff + 2'd1;
    num_d   = num_eff;
    base_d  = base_eff;
    if (complete) begin
      if (in_limit) begin
        base_d = base_eff + lpbu_pkg::IndexW'(seg_sat);
      end
      if (num_eff != lpbu_pkg::NumMax) begin
        num_d = num_eff + 1'b1;
      end
    end
  end

  assign sts_o.emit_start = complete && in_limit && (seg_sat != '0);
  assign sts_o.last_copy  = (cnt_q + 1'b1) == seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= lpbu_pkg::FmtRgb;
      first_q   <= '0;
      limit_q   <= '0;
      seg_cfg_q <= lpbu_pkg::SegW'(1);
      kind_q    <= lpbu_pkg::KindNone;
      xdef_q    <= '0;
      phase_q   <= '0;
      num_q     <= '0;
      base_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          lpbu_pkg::RegPixelFormat:  fmt_q     <= cfg_data_i[lpbu_pkg::FmtW-1:0];
          lpbu_pkg::RegFirstLed:     first_q   <= cfg_data_i[lpbu_pkg::FirstW-1:0];
          lpbu_pkg::RegPixelLimit:   limit_q   <= cfg_data_i[lpbu_pkg::LimitW-1:0];
          lpbu_pkg::RegSegmentLen:   seg_cfg_q <= cfg_data_i[lpbu_pkg::SegW-1:0];
          lpbu_pkg::RegExtraKind:    kind_q    <= cfg_data_i[lpbu_pkg::KindW-1:0];
          lpbu_pkg::RegExtraDefault: xdef_q    <= cfg_data_i[lpbu_pkg::ByteW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        phase_q <= phase_d;
        num_q   <= num_d;
        base_q  <= base_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (!complete) begin
        held_q[phase_eff] <= data_byte_i;
      end
      pr_q  <= r_d;
      pg_q  <= g_d;
      pb_q  <= b_d;
      px_q  <= x_d;
      idx_q <= lpbu_pkg::IndexW'(first_q) + base_eff;
      seg_q <= seg_sat;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= idx_q + 1'b1;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.load) begin
      led_q <= idx_q;
      r_q   <= pr_q;
      g_q   <= pg_q;
      b_q   <= pb_q;
      x_q   <= px_q;
      end_q <= sts_o.last_copy;
    end
  end

  assign led_index_o = led_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign extra_o     = x_q;
  assign run_end_o   = end_q;

endmodule

FILE: hdl/lpbu_checker.sv
// lpbu_checker: port-level assertions for the led pixel byte unpacker
// depends on lpbu_pkg; bound to led_pixel_byte_unpacker_core
module lpbu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lpbu_pkg::IndexW-1:0]   led_index_o,
  input logic [lpbu_pkg::ByteW-1:0]    red_o,
  input logic [lpbu_pkg::ByteW-1:0]    green_o,
  input logic [lpbu_pkg::ByteW-1:0]    blue_o,
  input logic [lpbu_pkg::ByteW-1:0]    extra_o,
  input logic                          run_end_o
);

  logic mid_beat;
  assign mid_beat = out_valid_o && !out_stall_i && !run_end_o;

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_index_o) &&
      $stable(red_o) && $stable(run_end_o))
    else $error("stalled output beat changed");

  // input waits while a run is still being copied out
  a_run_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !run_end_o |-> in_stall_o)
    else $error("input taken in the middle of a run");

  // next copy follows straight away
  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=> out_valid_o)
    else $error("gap inside a run");

  // copies of one pixel go to consecutive leds with the same colour
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_beat |=> led_index_o == $past(led_index_o) + 1'b1 &&
      $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(extra_o))
    else $error("run copy index or colour wrong");

endmodule

bind led_pixel_byte_unpacker_core lpbu_checker u_lpbu_checker (.*);

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for led_pixel_byte_unpacker_core
// holds a scoreboard class that predicts every led write from the accepted bytes
// depends on lpbu_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_top;
  import lpbu_pkg::*;

  localparam int CycleLimit = 4000000;
  localparam logic [FmtW-1:0]  FmtUnknown = 3'd6;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  typedef struct packed {
    logic [IndexW-1:0] led_index;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
    logic [ByteW-1:0]  extra;
    logic              run_end;
  } led_write_t;

  class led_write_predictor;
    led_write_t        pending_writes[$];
    int                errors;
    logic [FmtW-1:0]   fmt;
    logic [FirstW-1:0] first_led;
    logic [LimitW-1:0] pixel_limit;
    logic [SegW-1:0]   seg_len;
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  dflt;
    int                phase;
    logic [ByteW-1:0]  held[3];
    logic [NumW-1:0]   pix_num;
    logic [IndexW-1:0] base;

    function new();
      errors      = 0;
      fmt         = FmtRgb;
      first_led   = '0;
      pixel_limit = '0;
      seg_len     = 7'd1;
      kind        = KindNone;
      dflt        = '0;
      phase       = 0;
      held[0]     = '0;
      held[1]     = '0;
      held[2]     = '0;
      pix_num     = '0;
      base        = '0;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegPixelFormat:  fmt = data[FmtW-1:0];
        RegFirstLed:     first_led = data[FirstW-1:0];
        RegPixelLimit:   pixel_limit = data[LimitW-1:0];
        RegSegmentLen:   seg_len = data[SegW-1:0];
        RegExtraKind:    kind = data[KindW-1:0];
        RegExtraDefault: dflt = data[ByteW-1:0];
        default: ;
      endcase
    endfunction

    function void take_byte(logic [ByteW-1:0] cur, logic start);
      int               size;
      int               seg;
      logic [ByteW-1:0] b2, r, g, bl, x;
      led_write_t       w;
      if (start) begin
        phase   = 0;
        pix_num = '0;
        base    = '0;
      end
      size = (fmt == FmtRgba || fmt == FmtRgbw) ? 4 : 3;
      if (phase + 1 < size) begin
        held[phase] = cur;
        phase = phase + 1;
        return;
      end
      // a pixel held over from a four-byte format drops the current byte
      b2 = (phase == 2) ? cur : held[2];
      phase = 0;
      case (fmt)
        FmtBgr: begin
          bl = held[0];
          g  = held[1];
          r  = b2;
        end
        FmtGrb: begin
          g  = held[0];
          r  = held[1];
          bl = b2;
        end
        default: begin
          r  = held[0];
          g  = held[1];
          bl = b2;
        end
      endcase
      if ((fmt == FmtRgba && kind == KindDimmer) || (fmt == FmtRgbw && kind == KindWhite))
        x = cur;
      else
        x = dflt;
      seg = (seg_len > MaxSegment) ? MaxSegment : int'(seg_len);
      if (pix_num < pixel_limit) begin
        for (int j = 0; j < seg; j++) begin
          w.led_index = IndexW'(first_led + base + j);
          w.red       = r;
          w.green     = g;
          w.blue      = bl;
          w.extra     = x;
          w.run_end   = (j == seg - 1);
          pending_writes.push_back(w);
        end
        base = base + IndexW'(seg);
      end
      if (pix_num != NumMax) pix_num = pix_num + 1'b1;
    endfunction

    function void check_write(logic [IndexW-1:0] idx, logic [ByteW-1:0] r,
                              logic [ByteW-1:0] g, logic [ByteW-1:0] b,
                              logic [ByteW-1:0] x, logic re);
      led_write_t w;
      if (pending_writes.size() == 0) begin
        $error("led write beat with none expected: led_index %0d", idx);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      if (idx !== w.led_index) begin
        $error("led_index: expected %0d, got %0d", w.led_index, idx);
        errors++;
      end
      if (r !== w.red) begin
        $error("red: expected %0d, got %0d", w.red, r);
        errors++;
      end
      if (g !== w.green) begin
        $error("green: expected %0d, got %0d", w.green, g);
        errors++;
      end
      if (b !== w.blue) begin
        $error("blue: expected %0d, got %0d", w.blue, b);
        errors++;
      end
      if (x !== w.extra) begin
        $error("extra: expected %0d, got %0d", w.extra, x);
        errors++;
      end
      if (re !== w.run_end) begin
        $error("run_end: expected %0d, got %0d", w.run_end, re);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               buffer_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [IndexW-1:0]  led_index_o;
  logic [ByteW-1:0]   red_o;
  logic [ByteW-1:0]   green_o;
  logic [ByteW-1:0]   blue_o;
  logic [ByteW-1:0]   extra_o;
  logic               run_end_o;

  led_write_predictor pred = new();
  int                 cycle_count = 0;
  int                 hold_left = 0;
  int                 calm_left = 0;
  bit                 burst = 1'b0;
  int                 sent = 0;

  led_pixel_byte_unpacker_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .buffer_start_i (buffer_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_index_o    (led_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .extra_o        (extra_o),
    .run_end_o      (run_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) pred.take_byte(data_byte_i, buffer_start_i);
      if (out_valid_o && !out_stall_i)
        pred.check_write(led_index_o, red_o, green_o, blue_o, extra_o, run_end_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, with calm stretches
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm_left != 0) begin
      calm_left--;
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b0;
      case ($urandom_range(0, 19))
        0:             calm_left = $urandom_range(20, 80);
        1:             hold_left = $urandom_range(10, 30);
        2, 3, 4, 5, 6: hold_left = $urandom_range(1, 3);
        default: ;
      endcase
    end
  end

  task automatic pause_in();
    int n;
    n = 0;
    if (!burst) begin
      case ($urandom_range(0, 9))
        6, 7, 8: n = $urandom_range(1, 3);
        9:       n = $urandom_range(8, 25);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic send_byte(input logic [ByteW-1:0] b, input logic s);
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    buffer_start_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    pause_in();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pred.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    pred.set_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [FmtW-1:0] fmt, input logic [FirstW-1:0] first,
                           input logic [LimitW-1:0] lim, input logic [SegW-1:0] seg,
                           input logic [KindW-1:0] kind, input logic [ByteW-1:0] dflt);
    write_reg(RegPixelFormat, CfgW'(fmt));
    write_reg(RegFirstLed, CfgW'(first));
    write_reg(RegPixelLimit, CfgW'(lim));
    write_reg(RegSegmentLen, CfgW'(seg));
    write_reg(RegExtraKind, CfgW'(kind));
    write_reg(RegExtraDefault, CfgW'(dflt));
    cfg_we_i <= 1'b0;
  endtask

  task automatic rand_config(output int size);
    logic [FmtW-1:0]   fmt;
    logic [FirstW-1:0] first;
    logic [LimitW-1:0] lim;
    logic [SegW-1:0]   seg;
    logic [KindW-1:0]  kind;
    logic [ByteW-1:0]  dflt;
    fmt = FmtW'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       first = '0;
      1:       first = '1;
      default: first = FirstW'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 9))
      0:       lim = '0;
      1:       lim = '1;
      2, 3, 4: lim = LimitW'($urandom_range(1, 6));
      default: lim = LimitW'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 19))
      0:       seg = '0;
      1:       seg = 7'(MaxSegment);
      2:       seg = SegW'($urandom_range(65, 127));
      3:       seg = SegW'($urandom_range(9, 63));
      default: seg = SegW'($urandom_range(1, 8));
    endcase
    kind = KindW'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0:       dflt = '0;
      1:       dflt = '1;
      default: dflt = ByteW'($urandom_range(0, 255));
    endcase
    configure(fmt, first, lim, seg, kind, dflt);
    size = (fmt == FmtRgba || fmt == FmtRgbw) ? 4 : 3;
  endtask

  initial begin
    int size;
    int nb;
    bit open;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: pixel limit zero, no beats
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);

    drain();
    configure(FmtBgr, '1, '1, 7'd2, KindDimmer, 8'hFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);

    drain();
    configure(FmtRgbw, 12'd5, '1, 7'(MaxSegment), KindWhite, 8'h55);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);

    // kind does not match the format, segment above the maximum
    drain();
    configure(FmtRgbw, '0, '1, 7'd127, KindDimmer, 8'hA5);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'hFE, 1'b0);

    // zero segment: counted, no beats
    drain();
    configure(FmtGrb, '0, '1, '0, KindUnused, '0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);

    drain();
    configure(FmtUnknown, 12'd100, 12'd6, 7'd1, KindUnused, 8'h3C);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h99, 1'b0);
    send_byte(8'h66, 1'b0);

    // format change with three bytes held
    drain();
    configure(FmtRgba, '0, '1, 7'd3, KindDimmer, 8'h00);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b0);
    send_byte(8'hEF, 1'b0);
    drain();
    configure(FmtRgb, 12'd7, '1, 7'd3, KindNone, 8'h12);
    send_byte(8'h77, 1'b0);

    sent = 0;
    while (sent < 350) begin
      drain();
      rand_config(size);
      burst = ($urandom_range(0, 4) == 0);
      open  = ($urandom_range(0, 4) != 0);
      nb = size * $urandom_range(1, 10);
      if ($urandom_range(0, 2) == 0) nb += $urandom_range(1, size - 1);
      for (int k = 0; k < nb; k++) begin
        send_byte(ByteW'($urandom_range(0, 255)),
                  (k == 0 && open) || ($urandom_range(0, 39) == 0));
        if ($urandom_range(0, 59) == 0) begin
          drain();
          if ($urandom_range(0, 1) == 1) rand_config(size);
        end
      end
    end

    drain();
    repeat (16) @(negedge clk_i);
    if (pred.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
